[hdl/huffman_bit_packer_top_macros.svh]
// Assertion macros used by the packer RTL.
`ifndef HUFFMAN_BIT_PACKER_TOP_MACROS_SVH
`define HUFFMAN_BIT_PACKER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define HBP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hbp assertion failed");

// Next-cycle implication.
`define HBP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hbp assertion failed");

`endif

[hdl/hbp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package hbp_pkg;

  localparam int SYMBOL_COUNT = 256;
  localparam int MAX_CODE_LEN = 32;

  localparam int SYM_W  = 8;
  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int ADDR_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_ENCODE = 1'b1;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } tbl_req_t;

endpackage
`default_nettype wire

[hdl/hbp_table.sv]
`timescale 1ns / 1ps
`default_nettype none
module hbp_table
  import hbp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tbl_req_t          req_i,
  output logic      [CODE_W-1:0] code_o,
  output logic      [LEN_W-1:0]  len_o
);

  logic [CODE_W-1:0] code_mem [SYMBOL_COUNT];
  logic [LEN_W-1:0]  len_mem  [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] vld_q;

  logic [CODE_W-1:0] code_rd_q;
  logic [LEN_W-1:0]  len_rd_q;
  logic              vld_rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      code_mem[req_i.addr] <= req_i.code;
      len_mem[req_i.addr]  <= req_i.len;
    end
    if (req_i.re) begin
      code_rd_q <= code_mem[req_i.addr];
      len_rd_q  <= len_mem[req_i.addr];
    end
  end

  // per-entry valid bits give the all-zero length table after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.addr] <= 1'b1;
      end
      if (req_i.re) begin
        vld_rd_q <= vld_q[req_i.addr];
      end
    end
  end

  assign code_o = code_rd_q;
  assign len_o  = vld_rd_q ? len_rd_q : '0;

endmodule
`default_nettype wire

[hdl/huffman_bit_packer_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Huffman encoder bit packer.
// Input channel (in_valid_i / in_stall_o) takes one command per transaction:
// a load writes code word and length of one symbol into the table; an encode
// looks the symbol up and appends its code, bit 0 first, to the byte stream.
// Output channel (out_valid_o / out_stall_i) gives one byte per transaction,
// filled from bit 7 down; valid_bits_o is 8 except for the flushed partial byte
// of a final encode, and end_of_stream_o marks the last byte of the stream.
// A load yields nothing. An encode runs in steps: one to accept it and read
// the table, one to align the code behind the pending bits in a 40-bit shift
// word, then one byte at a time shifted out of that word while the output can
// take it, plus a closing step that keeps the leftover bits or flushes them.
// The first byte follows the table read and the alignment step, later while
// the output is stalled. The shift word is the one unit reused for every byte.
// While the output register is full and stalled, the sequencer waits; the
// input stays stalled until the current encode has been fully handled.
// Reset empties the pending bits, clears the output valid flag and marks every
// table entry unloaded (length zero); no clearing pass is needed.
module huffman_bit_packer_top
  import hbp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              cmd_i,
  input  wire logic [SYM_W-1:0]  symbol_i,
  input  wire logic [CODE_W-1:0] entry_code_i,
  input  wire logic [LEN_W-1:0]  entry_length_i,
  input  wire logic              final_symbol_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [7:0]        out_byte_o,
  output logic      [3:0]        valid_bits_o,
  output logic                   end_of_stream_o
);

  localparam int WORD_W = CODE_W + 8;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam logic [SYM_W-1:0] SYM_MAX = SYM_W'(SYMBOL_COUNT - 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_CODE_LEN);

  logic [1:0]        state_q, state_d;
  logic [6:0]        pend_q, pend_d;     // pending bits, oldest in bit 6
  logic [2:0]        pcnt_q, pcnt_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic [5:0]        cnt_q, cnt_d;
  logic              fin_q, sym_ok_q;

  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q, out_byte_d;
  logic [3:0]        vbits_q, vbits_d;
  logic              eos_q, eos_d;

  tbl_req_t          tbl_req;
  logic [CODE_W-1:0] tbl_code;
  logic [LEN_W-1:0]  tbl_len;

  logic              in_fire, sym_ok, out_free;
  logic [LEN_W-1:0]  len_eff;
  logic [CODE_W-1:0] rev_code;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign sym_ok     = (symbol_i <= SYM_MAX);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    tbl_req.we   = in_fire && (cmd_i == CMD_LOAD) && sym_ok;
    tbl_req.re   = in_fire && (cmd_i == CMD_ENCODE);
    tbl_req.addr = symbol_i[ADDR_W-1:0];
    tbl_req.code = entry_code_i;
    tbl_req.len  = (entry_length_i > LEN_MAX) ? LEN_MAX : entry_length_i;
  end

  hbp_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tbl_req),
    .code_o (tbl_code),
    .len_o  (tbl_len)
  );

  assign len_eff = sym_ok_q ? tbl_len : '0;

  // first code bit goes to the top
  always_comb begin
    for (int i = 0; i < CODE_W; i++) begin
      rev_code[i] = tbl_code[CODE_W-1-i];
    end
  end

  always_comb begin
    state_d     = state_q;
    pend_d      = pend_q;
    pcnt_d      = pcnt_q;
    word_d      = word_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    vbits_d     = vbits_q;
    eos_d       = eos_q;

    unique case (state_q)
      ST_IDLE: begin
        if (tbl_req.re) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        word_d  = {pend_q, {(WORD_W-7){1'b0}}}
                | ({rev_code & ~({CODE_W{1'b1}} >> len_eff), 8'b0} >> pcnt_q);
        cnt_d   = {3'b0, pcnt_q} + 6'(len_eff);
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          if (cnt_q >= 6'd8) begin
            out_valid_d = 1'b1;
            out_byte_d  = word_q[WORD_W-1 -: 8];
            vbits_d     = 4'd8;
            eos_d       = fin_q && (cnt_q == 6'd8);
            word_d      = word_q << 8;
            cnt_d       = cnt_q - 6'd8;
          end else begin
            state_d = ST_IDLE;
            if (fin_q) begin
              pend_d = '0;
              pcnt_d = '0;
              if (cnt_q != 6'd0) begin
                out_valid_d = 1'b1;
                out_byte_d  = word_q[WORD_W-1 -: 8];
                vbits_d     = {1'b0, cnt_q[2:0]};
                eos_d       = 1'b1;
              end
            end else begin
              pend_d = word_q[WORD_W-1 -: 7];
              pcnt_d = cnt_q[2:0];
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= '0;
      pcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      pcnt_q      <= pcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q     <= word_d;
    cnt_q      <= cnt_d;
    out_byte_q <= out_byte_d;
    vbits_q    <= vbits_d;
    eos_q      <= eos_d;
    if (in_fire) begin
      fin_q    <= final_symbol_i;
      sym_ok_q <= sym_ok;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign valid_bits_o    = vbits_q;
  assign end_of_stream_o = eos_q;

`include "huffman_bit_packer_top_macros.svh"

  `HBP_ASSERT_IMP(a_pend_clean, state_q == ST_IDLE, (pend_q & (7'h7F >> pcnt_q)) == 7'h00)
  `HBP_ASSERT_IMP(a_partial_eos, out_valid_o && (valid_bits_o != 4'd8), end_of_stream_o)
  `HBP_ASSERT_IMP(a_vbits_range, out_valid_o, (valid_bits_o != 4'd0) && (valid_bits_o <= 4'd8))
  `HBP_ASSERT_NXT(a_load_idle, in_fire && (cmd_i == CMD_LOAD), state_q == ST_IDLE)
  `HBP_ASSERT_NXT(a_final_flush, (state_q == ST_EMIT) && fin_q && out_free && (cnt_q < 6'd8),
                  (pcnt_q == 3'd0) && (state_q == ST_IDLE))

endmodule
`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import hbp_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 16;
  localparam int HOLD_CYCLES    = 250;
  localparam int POOL_SIZE      = 16;
  localparam int PHASE_ITEMS    = 100;

  typedef struct packed {
    logic [7:0] data;
    logic [3:0] nbits;
    logic       eos;
  } packed_byte_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              cmd_i;
  logic [SYM_W-1:0]  symbol_i;
  logic [CODE_W-1:0] entry_code_i;
  logic [LEN_W-1:0]  entry_length_i;
  logic              final_symbol_i;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [7:0]        out_byte_o;
  logic [3:0]        valid_bits_o;
  logic              end_of_stream_o;

  // shadow of the symbol table and the partial byte
  logic [CODE_W-1:0] code_shadow [SYMBOL_COUNT];
  logic [LEN_W-1:0]  len_shadow [SYMBOL_COUNT];
  logic [7:0]        pend_bits;
  int                pend_cnt;

  packed_byte_t      expected_bytes [$];
  packed_byte_t      head_byte;

  int errors;
  int n_items;
  int n_loads;
  int n_finals;
  int n_bytes;
  int idle_pct;
  int stall_pct;
  int hold_seq;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  huffman_bit_packer_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .symbol_i        (symbol_i),
    .entry_code_i    (entry_code_i),
    .entry_length_i  (entry_length_i),
    .final_symbol_i  (final_symbol_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .valid_bits_o    (valid_bits_o),
    .end_of_stream_o (end_of_stream_o)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Bit-serial packing of one accepted command into expected bytes.
  task automatic pack_expected_bytes(input logic cmd, input logic [7:0] sym,
                                     input logic [31:0] code, input logic [5:0] len,
                                     input logic fin);
    int           nlen;
    int           made;
    logic [31:0]  cw;
    packed_byte_t rec;
    made = 0;
    if (cmd == CMD_LOAD) begin
      code_shadow[sym] = code;
      len_shadow[sym]  = (len > MAX_CODE_LEN) ? LEN_W'(MAX_CODE_LEN) : len;
    end else begin
      cw   = code_shadow[sym];
      nlen = len_shadow[sym];
      for (int j = 0; j < nlen; j++) begin
        pend_bits = {pend_bits[6:0], cw[j]};
        pend_cnt++;
        if (pend_cnt == 8) begin
          rec.data  = pend_bits;
          rec.nbits = 4'd8;
          rec.eos   = 1'b0;
          expected_bytes.push_back(rec);
          made++;
          pend_bits = '0;
          pend_cnt  = 0;
        end
      end
      if (fin) begin
        if (pend_cnt > 0) begin
          rec.data  = pend_bits << (8 - pend_cnt);
          rec.nbits = 4'(pend_cnt);
          rec.eos   = 1'b1;
          expected_bytes.push_back(rec);
        end else if (made > 0) begin
          // no partial byte: the last full byte closes the stream
          rec     = expected_bytes.pop_back();
          rec.eos = 1'b1;
          expected_bytes.push_back(rec);
        end
        pend_bits = '0;
        pend_cnt  = 0;
      end
    end
  endtask

  task automatic send_item(input logic cmd, input logic [7:0] sym, input logic [31:0] code,
                           input logic [5:0] len, input logic fin);
    bit done;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    cmd_i          = cmd;
    symbol_i       = sym;
    entry_code_i   = code;
    entry_length_i = len;
    final_symbol_i = fin;
    done = 1'b0;
    while (!done) begin
      @(posedge clk_i);
      if (!in_stall_o) begin
        pack_expected_bytes(cmd, sym, code, len, fin);
        n_items++;
        if (cmd == CMD_LOAD) n_loads++;
        else if (fin) n_finals++;
        done = 1'b1;
      end
      @(negedge clk_i);
    end
  endtask

  task automatic wait_drain();
    in_valid_i = 1'b0;
    while (expected_bytes.size() > 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [5:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 6'd0;
    if (r < 20) return 6'($urandom_range(33, 63));
    if (r < 30) return 6'd32;
    if (r < 50) return 6'($urandom_range(13, 31));
    return 6'($urandom_range(1, 12));
  endfunction

  function automatic logic [7:0] pick_symbol();
    if ($urandom_range(99) < 70) return 8'($urandom_range(0, POOL_SIZE - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic test_unloaded_symbols();
    send_item(CMD_ENCODE, 8'd200, 32'hFFFF_FFFF, 6'd32, 1'b0);
    send_item(CMD_ENCODE, 8'd201, 32'h0000_0000, 6'd0, 1'b1);
  endtask

  task automatic test_table_extremes();
    send_item(CMD_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32, 1'b0);
    send_item(CMD_LOAD, 8'd0, 32'h0000_0000, 6'd32, 1'b0);
    send_item(CMD_LOAD, 8'd1, 32'hA5A5_5A5A, 6'd63, 1'b0);  // saturates to 32
    send_item(CMD_LOAD, 8'd2, 32'hDEAD_BEEF, 6'd0, 1'b0);
    send_item(CMD_LOAD, 8'd3, 32'h0000_0001, 6'd1, 1'b0);
    send_item(CMD_LOAD, 8'd4, 32'h0000_0055, 6'd7, 1'b0);
    send_item(CMD_LOAD, 8'd5, 32'h0000_00C3, 6'd8, 1'b1);  // final flag ignored on load
    // 104 bits: ends on a byte boundary, eos rides the last full byte
    send_item(CMD_ENCODE, 8'd255, 32'h0, 6'd0, 1'b0);
    send_item(CMD_ENCODE, 8'd0, 32'h0, 6'd0, 1'b0);
    send_item(CMD_ENCODE, 8'd1, 32'h0, 6'd0, 1'b0);
    send_item(CMD_ENCODE, 8'd2, 32'h0, 6'd0, 1'b0);
    send_item(CMD_ENCODE, 8'd3, 32'h0, 6'd0, 1'b0);
    send_item(CMD_ENCODE, 8'd4, 32'h0, 6'd0, 1'b1);
    send_item(CMD_ENCODE, 8'd3, 32'h0, 6'd0, 1'b1);  // one-bit flush
    send_item(CMD_ENCODE, 8'd5, 32'h0, 6'd0, 1'b1);  // exactly one byte
    send_item(CMD_ENCODE, 8'd4, 32'h0, 6'd0, 1'b0);
    send_item(CMD_ENCODE, 8'd2, 32'h0, 6'd0, 1'b1);  // zero-length final flushes 7 bits
  endtask

  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    hold_seq++;
    for (int k = 0; k < 30; k++)
      send_item(CMD_ENCODE, 8'($urandom_range(0, POOL_SIZE - 1)), $urandom(),
                6'($urandom_range(0, 63)), k == 29);
    wait_drain();
  endtask

  task automatic random_traffic(input int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 15)
        send_item(CMD_LOAD, pick_symbol(), $urandom(), pick_length(), 1'($urandom_range(1)));
      else
        send_item(CMD_ENCODE, pick_symbol(), $urandom(), 6'($urandom_range(0, 63)),
                  $urandom_range(99) < 12);
    end
  endtask

  task automatic test_random_phases();
    for (int s = 0; s < POOL_SIZE; s++)
      send_item(CMD_LOAD, 8'(s), $urandom(), 6'($urandom_range(1, 32)), 1'b0);
    idle_pct = 0;  stall_pct = 0;  random_traffic(PHASE_ITEMS);  wait_drain();
    idle_pct = 84; stall_pct = 0;  random_traffic(PHASE_ITEMS);  wait_drain();
    idle_pct = 0;  stall_pct = 84; random_traffic(PHASE_ITEMS);  wait_drain();
    idle_pct = 13; stall_pct = 13; random_traffic(PHASE_ITEMS);  wait_drain();
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen   <= hold_seq;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_bytes++;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte: expected none, actual %h/%0d/%b", $time,
                 out_byte_o, valid_bits_o, end_of_stream_o);
      end else begin
        head_byte = expected_bytes.pop_front();
        if (out_byte_o !== head_byte.data) begin
          errors++;
          $display("%0t: out_byte expected %h actual %h", $time, head_byte.data, out_byte_o);
        end
        if (valid_bits_o !== head_byte.nbits) begin
          errors++;
          $display("%0t: valid_bits expected %0d actual %0d", $time, head_byte.nbits,
                   valid_bits_o);
        end
        if (end_of_stream_o !== head_byte.eos) begin
          errors++;
          $display("%0t: end_of_stream expected %b actual %b", $time, head_byte.eos,
                   end_of_stream_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no transaction for %0d cycles, %0d bytes outstanding",
                 $time, WATCHDOG_LIMIT, expected_bytes.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    cmd_i          = CMD_LOAD;
    symbol_i       = '0;
    entry_code_i   = '0;
    entry_length_i = '0;
    final_symbol_i = 1'b0;
    errors    = 0;
    n_items   = 0;
    n_loads   = 0;
    n_finals  = 0;
    n_bytes   = 0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_seq  = 0;
    pend_bits = '0;
    pend_cnt  = 0;
    for (int s = 0; s < SYMBOL_COUNT; s++) begin
      code_shadow[s] = '0;
      len_shadow[s]  = '0;
    end
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_unloaded_symbols();
    test_table_extremes();
    wait_drain();
    test_backpressure();
    test_random_phases();

    if (expected_bytes.size() != 0) begin
      errors++;
      $display("%0t: %0d expected bytes never arrived", $time, expected_bytes.size());
    end
    $display("Sent %0d commands (%0d table loads, %0d stream ends), checked %0d bytes,",
             n_items, n_loads, n_finals, n_bytes);
    $display("under free flow, sender gaps, receiver stalls and a long output hold-off.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
